// ===== hdl/lskr_pkg.sv =====
// ----------------------------------------------------------------------------
// lskr_pkg
// Shared types and constants for the LWE shared key reconciliation block.
// ----------------------------------------------------------------------------
package lskr_pkg;

    localparam int MOD_W   = 32;
    localparam int CNT_W   = $clog2(MOD_W);
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;

    localparam logic [MOD_W-1:0] MODULUS_RESET = MOD_W'(4093);

    // Register word index, taken from paddr above the byte lanes
    localparam logic [PADDR_W-3:0] REG_MODULUS = '0;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_RED_LOAD,
        ST_REDUCE,
        ST_MUL_LOAD,
        ST_MUL_DBL,
        ST_MUL_ADD,
        ST_ACC_ADD,
        ST_KEY_ADD0,
        ST_KEY_ADD1,
        ST_SIGNAL,
        ST_SHARED,
        ST_RESULT
    } lskr_state_t;

    // Operand being brought below the modulus
    typedef enum logic [1:0] {
        OPD_PUB,
        OPD_SECRET,
        OPD_NOISE,
        OPD_ACC
    } lskr_opd_t;

    // Datapath operation for the current cycle
    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_RED_START,
        OP_RED_STEP,
        OP_MUL_START,
        OP_MUL_DBL,
        OP_MUL_ADD,
        OP_ACC_ADD,
        OP_KEY_ADD,
        OP_SIGNAL,
        OP_SHARED,
        OP_RESULT
    } lskr_op_t;

    typedef struct packed {
        lskr_op_t  op;
        lskr_opd_t sel;
        logic      step_last;
    } lskr_ctrl_t;

    typedef struct packed {
        logic p_small;
        logic item_last;
        logic out_free;
    } lskr_stat_t;

endpackage

// ===== hdl/lskr_if.sv =====
// ----------------------------------------------------------------------------
// lskr_if
// Valid/ready channels for input pairs and reconciliation results.
// ----------------------------------------------------------------------------
interface lskr_in_if;
    logic                       valid;
    logic                       ready;
    logic [lskr_pkg::MOD_W-1:0] pub_elem;
    logic [lskr_pkg::MOD_W-1:0] secret_elem;
    logic [lskr_pkg::MOD_W-1:0] noise_term;
    logic                       rand_bit;
    logic                       last_elem;

    modport source (
        output valid, pub_elem, secret_elem, noise_term, rand_bit, last_elem,
        input  ready
    );
    modport sink (
        input  valid, pub_elem, secret_elem, noise_term, rand_bit, last_elem,
        output ready
    );
endinterface

interface lskr_out_if;
    logic                       valid;
    logic                       ready;
    logic                       signal_bit;
    logic                       shared_bit;
    logic [lskr_pkg::MOD_W-1:0] key_value;

    modport source (
        output valid, signal_bit, shared_bit, key_value,
        input  ready
    );
    modport sink (
        input  valid, signal_bit, shared_bit, key_value,
        output ready
    );
endinterface

// ===== hdl/lskr_modadd.sv =====
// ----------------------------------------------------------------------------
// lskr_modadd
// Shared modular adder: (x + y + cin) mod p for x + y + cin below 2p.
// ----------------------------------------------------------------------------
module lskr_modadd (
    input  logic [lskr_pkg::MOD_W-1:0] x,
    input  logic [lskr_pkg::MOD_W-1:0] y,
    input  logic                       cin,
    input  logic [lskr_pkg::MOD_W-1:0] p,
    output logic [lskr_pkg::MOD_W-1:0] sum
);

    logic [lskr_pkg::MOD_W:0]   raw;
    logic [lskr_pkg::MOD_W+1:0] diff;

    assign raw  = {1'b0, x} + {1'b0, y} + {{lskr_pkg::MOD_W{1'b0}}, cin};
    assign diff = {1'b0, raw} - {2'b00, p};
    // no borrow means raw >= p: take one modulus off
    assign sum  = diff[lskr_pkg::MOD_W+1] ? raw[lskr_pkg::MOD_W-1:0]
                                           : diff[lskr_pkg::MOD_W-1:0];

endmodule

// ===== hdl/lskr_cfg.sv =====
// ----------------------------------------------------------------------------
// lskr_cfg
// APB register file holding the modulus.
// ----------------------------------------------------------------------------
module lskr_cfg (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [lskr_pkg::PADDR_W-1:0] paddr,
    input  logic [lskr_pkg::PDATA_W-1:0] pwdata,
    output logic [lskr_pkg::PDATA_W-1:0] prdata,
    output logic                         pready,
    output logic [lskr_pkg::MOD_W-1:0]   modulus
);

    logic [lskr_pkg::MOD_W-1:0]   modulus_reg;
    logic [lskr_pkg::MOD_W-1:0]   modulus_next;
    logic [lskr_pkg::PADDR_W-3:0] word_idx;
    logic                         wr_modulus;

    assign word_idx   = paddr[lskr_pkg::PADDR_W-1:2];
    assign wr_modulus = psel && penable && pwrite && pready
                        && (word_idx == lskr_pkg::REG_MODULUS);

    always_comb
    begin
        modulus_next = modulus_reg;
        if (wr_modulus)
        begin
            modulus_next = pwdata[lskr_pkg::MOD_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            modulus_reg <= lskr_pkg::MODULUS_RESET;
        end
        else
        begin
            modulus_reg <= modulus_next;
        end
    end

    assign pready  = 1'b1;
    assign modulus = modulus_reg;
    assign prdata  = (word_idx == lskr_pkg::REG_MODULUS) ? modulus_reg : '0;

endmodule

// ===== hdl/lskr_ctrl.sv =====
// ----------------------------------------------------------------------------
// lskr_ctrl
// Sequencer: steps reductions, the bit-serial multiply and the key tail.
// ----------------------------------------------------------------------------
module lskr_ctrl (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    input  logic                   in_last,
    input  lskr_pkg::lskr_stat_t   stat,
    output logic                   in_ready,
    output lskr_pkg::lskr_ctrl_t   ctrl
);

    lskr_pkg::lskr_state_t      state_reg;
    lskr_pkg::lskr_state_t      state_next;
    lskr_pkg::lskr_opd_t        sel_reg;
    lskr_pkg::lskr_opd_t        sel_next;
    logic [lskr_pkg::CNT_W-1:0] cnt_reg;
    logic [lskr_pkg::CNT_W-1:0] cnt_next;
    logic                       cnt_zero;
    logic                       accept;

    assign cnt_zero = (cnt_reg == '0);
    assign accept   = in_valid && in_ready;

    // next state
    always_comb
    begin
        state_next = state_reg;
        sel_next   = sel_reg;
        cnt_next   = cnt_reg;
        case (state_reg)
            lskr_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    sel_next = lskr_pkg::OPD_PUB;
                    if (!stat.p_small)
                    begin
                        state_next = lskr_pkg::ST_RED_LOAD;
                    end
                    else if (in_last)
                    begin
                        state_next = lskr_pkg::ST_RESULT;
                    end
                end
            end
            lskr_pkg::ST_RED_LOAD:
            begin
                cnt_next   = lskr_pkg::CNT_W'(lskr_pkg::MOD_W - 1);
                state_next = lskr_pkg::ST_REDUCE;
            end
            lskr_pkg::ST_REDUCE:
            begin
                cnt_next = cnt_reg - 1'b1;
                if (cnt_zero)
                begin
                    state_next = lskr_pkg::ST_RED_LOAD;
                    case (sel_reg)
                        lskr_pkg::OPD_PUB:
                        begin
                            sel_next = lskr_pkg::OPD_SECRET;
                        end
                        lskr_pkg::OPD_SECRET:
                        begin
                            sel_next = stat.item_last ? lskr_pkg::OPD_NOISE
                                                      : lskr_pkg::OPD_ACC;
                        end
                        lskr_pkg::OPD_NOISE:
                        begin
                            sel_next = lskr_pkg::OPD_ACC;
                        end
                        default:
                        begin
                            state_next = lskr_pkg::ST_MUL_LOAD;
                        end
                    endcase
                end
            end
            lskr_pkg::ST_MUL_LOAD:
            begin
                cnt_next   = lskr_pkg::CNT_W'(lskr_pkg::MOD_W - 1);
                state_next = lskr_pkg::ST_MUL_DBL;
            end
            lskr_pkg::ST_MUL_DBL:
            begin
                state_next = lskr_pkg::ST_MUL_ADD;
            end
            lskr_pkg::ST_MUL_ADD:
            begin
                cnt_next   = cnt_reg - 1'b1;
                state_next = cnt_zero ? lskr_pkg::ST_ACC_ADD : lskr_pkg::ST_MUL_DBL;
            end
            lskr_pkg::ST_ACC_ADD:
            begin
                state_next = stat.item_last ? lskr_pkg::ST_KEY_ADD0 : lskr_pkg::ST_IDLE;
            end
            lskr_pkg::ST_KEY_ADD0:
            begin
                state_next = lskr_pkg::ST_KEY_ADD1;
            end
            lskr_pkg::ST_KEY_ADD1:
            begin
                state_next = lskr_pkg::ST_SIGNAL;
            end
            lskr_pkg::ST_SIGNAL:
            begin
                state_next = lskr_pkg::ST_SHARED;
            end
            lskr_pkg::ST_SHARED:
            begin
                state_next = lskr_pkg::ST_RESULT;
            end
            lskr_pkg::ST_RESULT:
            begin
                if (stat.out_free)
                begin
                    state_next = lskr_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = lskr_pkg::ST_IDLE;
            end
        endcase
    end

    // outputs
    always_comb
    begin
        in_ready       = 1'b0;
        ctrl.op        = lskr_pkg::OP_NONE;
        ctrl.sel       = sel_reg;
        ctrl.step_last = cnt_zero;
        case (state_reg)
            lskr_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (accept)
                begin
                    ctrl.op = lskr_pkg::OP_LOAD;
                end
            end
            lskr_pkg::ST_RED_LOAD: ctrl.op = lskr_pkg::OP_RED_START;
            lskr_pkg::ST_REDUCE:   ctrl.op = lskr_pkg::OP_RED_STEP;
            lskr_pkg::ST_MUL_LOAD: ctrl.op = lskr_pkg::OP_MUL_START;
            lskr_pkg::ST_MUL_DBL:  ctrl.op = lskr_pkg::OP_MUL_DBL;
            lskr_pkg::ST_MUL_ADD:  ctrl.op = lskr_pkg::OP_MUL_ADD;
            lskr_pkg::ST_ACC_ADD:  ctrl.op = lskr_pkg::OP_ACC_ADD;
            lskr_pkg::ST_KEY_ADD0: ctrl.op = lskr_pkg::OP_KEY_ADD;
            lskr_pkg::ST_KEY_ADD1: ctrl.op = lskr_pkg::OP_KEY_ADD;
            lskr_pkg::ST_SIGNAL:   ctrl.op = lskr_pkg::OP_SIGNAL;
            lskr_pkg::ST_SHARED:   ctrl.op = lskr_pkg::OP_SHARED;
            lskr_pkg::ST_RESULT:
            begin
                if (stat.out_free)
                begin
                    ctrl.op = lskr_pkg::OP_RESULT;
                end
            end
            default:
            begin
                ctrl.op = lskr_pkg::OP_NONE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= lskr_pkg::ST_IDLE;
            sel_reg   <= lskr_pkg::OPD_PUB;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            sel_reg   <= sel_next;
            cnt_reg   <= cnt_next;
        end
    end

endmodule

// ===== hdl/lskr_dp.sv =====
// ----------------------------------------------------------------------------
// lskr_dp
// Datapath: operand and accumulator registers around the shared modular
// adder, signal region compare and the result register.
// ----------------------------------------------------------------------------
module lskr_dp (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic [lskr_pkg::MOD_W-1:0] modulus,
    input  lskr_pkg::lskr_ctrl_t       ctrl,
    input  logic [lskr_pkg::MOD_W-1:0] pub_elem,
    input  logic [lskr_pkg::MOD_W-1:0] secret_elem,
    input  logic [lskr_pkg::MOD_W-1:0] noise_term,
    input  logic                       rand_bit,
    input  logic                       last_elem,
    input  logic                       out_ready,
    output logic                       out_valid,
    output logic                       signal_bit,
    output logic                       shared_bit,
    output logic [lskr_pkg::MOD_W-1:0] key_value,
    output lskr_pkg::lskr_stat_t       stat
);

    localparam int W = lskr_pkg::MOD_W;

    logic [W-1:0] a_reg, a_next;
    logic [W-1:0] s_reg, s_next;
    logic [W-1:0] e_reg, e_next;
    logic [W-1:0] acc_reg, acc_next;
    logic [W-1:0] src_reg, src_next;
    logic [W-1:0] w_reg, w_next;
    logic         b_reg, b_next;
    logic         last_reg, last_next;
    logic         sig_reg, sig_next;
    logic         out_valid_reg, out_valid_next;
    logic         out_sig_reg, out_sig_next;
    logic         out_shared_reg, out_shared_next;
    logic [W-1:0] out_key_reg, out_key_next;

    logic [W-1:0] ux, uy, usum, half, quarter;
    logic         ucin, p_small, src_msb, sig_eval;
    logic [W:0]   lo_bound, hi_bound;

    assign p_small = (modulus[W-1:1] == '0);
    assign src_msb = src_reg[W-1];
    assign quarter = modulus >> 2;
    assign half    = (modulus - 1'b1) >> 1;

    // signal region: rand_bit shifts both bounds up by one
    assign lo_bound = {1'b0, quarter} + {{W{1'b0}}, b_reg};
    assign hi_bound = {1'b0, modulus - quarter} + {{W{1'b0}}, b_reg};
    assign sig_eval = ({1'b0, acc_reg} > lo_bound) && ({1'b0, acc_reg} < hi_bound);

    // shared unit operand select
    always_comb
    begin
        ux   = '0;
        uy   = '0;
        ucin = 1'b0;
        case (ctrl.op)
            lskr_pkg::OP_RED_STEP:
            begin
                ux   = w_reg;
                uy   = w_reg;
                ucin = src_msb;
            end
            lskr_pkg::OP_MUL_DBL:
            begin
                ux = w_reg;
                uy = w_reg;
            end
            lskr_pkg::OP_MUL_ADD:
            begin
                ux = w_reg;
                uy = a_reg;
            end
            lskr_pkg::OP_ACC_ADD:
            begin
                ux = acc_reg;
                uy = w_reg;
            end
            lskr_pkg::OP_KEY_ADD:
            begin
                ux = acc_reg;
                uy = e_reg;
            end
            lskr_pkg::OP_SHARED:
            begin
                ux = acc_reg;
                uy = half;
            end
            default:
            begin
                ux = '0;
            end
        endcase
    end

    lskr_modadd u_modadd (
        .x   (ux),
        .y   (uy),
        .cin (ucin),
        .p   (modulus),
        .sum (usum)
    );

    always_comb
    begin
        a_next          = a_reg;
        s_next          = s_reg;
        e_next          = e_reg;
        acc_next        = acc_reg;
        src_next        = src_reg;
        w_next          = w_reg;
        b_next          = b_reg;
        last_next       = last_reg;
        sig_next        = sig_reg;
        out_sig_next    = out_sig_reg;
        out_shared_next = out_shared_reg;
        out_key_next    = out_key_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        case (ctrl.op)
            lskr_pkg::OP_LOAD:
            begin
                a_next    = pub_elem;
                s_next    = secret_elem;
                e_next    = noise_term;
                b_next    = rand_bit;
                last_next = last_elem;
                if (p_small)
                begin
                    // every residue is zero under a trivial modulus
                    acc_next = '0;
                    w_next   = '0;
                    sig_next = 1'b0;
                end
            end
            lskr_pkg::OP_RED_START:
            begin
                w_next = '0;
                case (ctrl.sel)
                    lskr_pkg::OPD_PUB:    src_next = a_reg;
                    lskr_pkg::OPD_SECRET: src_next = s_reg;
                    lskr_pkg::OPD_NOISE:  src_next = e_reg;
                    default:              src_next = acc_reg;
                endcase
            end
            lskr_pkg::OP_RED_STEP:
            begin
                w_next   = usum;
                src_next = src_reg << 1;
                if (ctrl.step_last)
                begin
                    case (ctrl.sel)
                        lskr_pkg::OPD_PUB:    a_next   = usum;
                        lskr_pkg::OPD_SECRET: s_next   = usum;
                        lskr_pkg::OPD_NOISE:  e_next   = usum;
                        default:              acc_next = usum;
                    endcase
                end
            end
            lskr_pkg::OP_MUL_START:
            begin
                src_next = s_reg;
                w_next   = '0;
            end
            lskr_pkg::OP_MUL_DBL:
            begin
                w_next = usum;
            end
            lskr_pkg::OP_MUL_ADD:
            begin
                if (src_msb)
                begin
                    w_next = usum;
                end
                src_next = src_reg << 1;
            end
            lskr_pkg::OP_ACC_ADD,
            lskr_pkg::OP_KEY_ADD:
            begin
                acc_next = usum;
            end
            lskr_pkg::OP_SIGNAL:
            begin
                sig_next = sig_eval;
            end
            lskr_pkg::OP_SHARED:
            begin
                w_next = sig_reg ? usum : acc_reg;
            end
            lskr_pkg::OP_RESULT:
            begin
                out_valid_next  = 1'b1;
                out_sig_next    = sig_reg;
                out_shared_next = w_reg[0];
                out_key_next    = acc_reg;
                acc_next        = '0;
            end
            default:
            begin
                w_next = w_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            acc_reg       <= '0;
            last_reg      <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            acc_reg       <= acc_next;
            last_reg      <= last_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg          <= a_next;
        s_reg          <= s_next;
        e_reg          <= e_next;
        src_reg        <= src_next;
        w_reg          <= w_next;
        b_reg          <= b_next;
        sig_reg        <= sig_next;
        out_sig_reg    <= out_sig_next;
        out_shared_reg <= out_shared_next;
        out_key_reg    <= out_key_next;
    end

    assign out_valid      = out_valid_reg;
    assign signal_bit     = out_sig_reg;
    assign shared_bit     = out_shared_reg;
    assign key_value      = out_key_reg;
    assign stat.p_small   = p_small;
    assign stat.item_last = last_reg;
    assign stat.out_free  = !out_valid_reg || out_ready;

`ifndef ASSERT_OFF
    a_result_loads: assert property (@(posedge clk) disable iff (!rst_n)
        (ctrl.op == lskr_pkg::OP_RESULT) |=> out_valid_reg)
        else $error("result write did not raise out_valid");

    a_mul_reduced: assert property (@(posedge clk) disable iff (!rst_n)
        (ctrl.op == lskr_pkg::OP_MUL_ADD) |=> (w_reg < modulus))
        else $error("partial product not below modulus");

    a_key_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> ((p_small && out_key_reg == '0)
                           || (!p_small && out_key_reg < modulus)))
        else $error("key value out of range");

    a_shared_plain: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_sig_reg) |-> (out_shared_reg == out_key_reg[0]))
        else $error("shared bit differs from key parity with signal clear");
`endif

endmodule

// ===== hdl/lwe_shared_key_reconcile.sv =====
// ----------------------------------------------------------------------------
// lwe_shared_key_reconcile
// Responder-side LWE key reconciliation: modular inner product of element
// pairs, noise addition, signal bit and shared key bit.
// ----------------------------------------------------------------------------
//  channel   | dir | handshake       | payload
//  ----------+-----+-----------------+----------------------------------------
//  item_in   | in  | valid / ready   | pub_elem, secret_elem, noise_term,
//            |     |                 | rand_bit, last_elem
//  result    | out | valid / ready   | signal_bit, shared_bit, key_value
//  apb       | in  | psel / penable  | modulus at byte address 0
//
//  Operation: one transaction at a time. With p >= 2 a non-last pair goes
//  through three reductions, a bit-serial multiply and the accumulate; a
//  last pair adds the noise reduction and the key tail on top. The shared
//  modular adder does one step per cycle. With p below 2 a pair skips all
//  of this, and a last pair goes straight to the result.
//  Reset clears the sequencer, the accumulator and the result valid; the
//  modulus returns to 4093. A stalled result is held in the output register;
//  the next pair is taken while it waits, and only the final write of the
//  following key waits for the slot.
// ----------------------------------------------------------------------------
module lwe_shared_key_reconcile (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [lskr_pkg::PADDR_W-1:0] paddr,
    input  logic [lskr_pkg::PDATA_W-1:0] pwdata,
    output logic [lskr_pkg::PDATA_W-1:0] prdata,
    output logic                         pready,
    lskr_in_if.sink                      item_in,
    lskr_out_if.source                   result
);

    logic [lskr_pkg::MOD_W-1:0] modulus;
    lskr_pkg::lskr_ctrl_t       ctrl;
    lskr_pkg::lskr_stat_t       stat;

    // Modulus register; to be written only while the block is idle, unenforced
    lskr_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .modulus (modulus)
    );

    // Sequencer: hold ready low for the whole of a transaction's work
    lskr_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (item_in.valid),
        .in_last  (item_in.last_elem),
        .stat     (stat),
        .in_ready (item_in.ready),
        .ctrl     (ctrl)
    );

    // Datapath: reduce operands, multiply-accumulate, derive the key bits
    lskr_dp u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .modulus     (modulus),
        .ctrl        (ctrl),
        .pub_elem    (item_in.pub_elem),
        .secret_elem (item_in.secret_elem),
        .noise_term  (item_in.noise_term),
        .rand_bit    (item_in.rand_bit),
        .last_elem   (item_in.last_elem),
        .out_ready   (result.ready),
        .out_valid   (result.valid),
        .signal_bit  (result.signal_bit),
        .shared_bit  (result.shared_bit),
        .key_value   (result.key_value),
        .stat        (stat)
    );

endmodule

// ===== verif/lskr_checker.sv =====
// ----------------------------------------------------------------------------
// lskr_checker
// Watches the pair and result channels and the register port of the key
// reconciliation block. Keeps its own inner product and modulus, predicts each
// key, compares it field by field and hands the mismatch count to the top.
// ----------------------------------------------------------------------------
module lskr_checker (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic                         pready,
    input  logic [lskr_pkg::PADDR_W-1:0] paddr,
    input  logic [lskr_pkg::PDATA_W-1:0] pwdata,
    input  logic [lskr_pkg::PDATA_W-1:0] prdata,
    lskr_in_if                           item_in,
    lskr_out_if                          result,
    output int                           fail_count,
    output int                           keys_waiting
);

    localparam int WIDE = 2 * lskr_pkg::MOD_W;

    typedef struct packed {
        logic                       signal_bit;
        logic                       shared_bit;
        logic [lskr_pkg::MOD_W-1:0] key_value;
    } recon_t;

    logic [lskr_pkg::MOD_W-1:0] modulus;
    logic [WIDE-1:0]            dot_acc;
    recon_t                     keys_due[$];
    int                         errors    = 0;
    int                         keys_seen = 0;

    task automatic report(input string msg);
        errors++;
        $display("%0t lskr_checker: %s", $time, msg);
    endtask

    // Modular multiply-accumulate; a modulus below 2 collapses every residue
    function automatic logic [WIDE-1:0] mac_mod(input logic [WIDE-1:0]            acc,
                                                input logic [lskr_pkg::MOD_W-1:0] a,
                                                input logic [lskr_pkg::MOD_W-1:0] s,
                                                input logic [WIDE-1:0]            p);
        logic [WIDE-1:0] prod;
        if (p < 2)
            return '0;
        prod = ((WIDE'(a) % p) * (WIDE'(s) % p)) % p;
        return ((acc % p) + prod) % p;
    endfunction

    function automatic recon_t reconcile(input logic [WIDE-1:0]            acc,
                                         input logic [lskr_pkg::MOD_W-1:0] noise,
                                         input logic                       rb,
                                         input logic [WIDE-1:0]            p);
        recon_t          r;
        logic [WIDE-1:0] k;
        logic [WIDE-1:0] q;
        logic [WIDE-1:0] lo;
        logic [WIDE-1:0] hi;
        logic [WIDE-1:0] sk;
        logic            sig;
        r = '0;
        if (p < 2)
            return r;
        k   = (acc + 2 * (WIDE'(noise) % p)) % p;
        q   = p / 4;
        lo  = rb ? q + 1 : q;
        hi  = rb ? p - q + 1 : p - q;
        sig = (k > lo) && (k < hi);
        sk  = sig ? (k + (p - 1) / 2) % p : k;
        r.signal_bit = sig;
        r.shared_bit = sk[0];
        r.key_value  = k[lskr_pkg::MOD_W-1:0];
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        recon_t          got;
        recon_t          want;
        string           bad;
        logic [WIDE-1:0] p;
        if (!rst_n)
        begin
            modulus = lskr_pkg::MODULUS_RESET;
            dot_acc = '0;
            keys_due.delete();
        end
        else
        begin
            p = WIDE'(modulus);

            if (psel && penable && pready
                && paddr[lskr_pkg::PADDR_W-1:2] == lskr_pkg::REG_MODULUS)
            begin
                if (pwrite)
                    modulus = pwdata[lskr_pkg::MOD_W-1:0];
                else if (prdata !== lskr_pkg::PDATA_W'(modulus))
                    report($sformatf("modulus read %0h, want %0h", prdata, modulus));
            end

            if (result.valid && result.ready)
            begin
                got.signal_bit = result.signal_bit;
                got.shared_bit = result.shared_bit;
                got.key_value  = result.key_value;
                keys_seen++;
                if (keys_due.size() == 0)
                    report($sformatf("key %0d arrived with none due", keys_seen));
                else
                begin
                    want = keys_due.pop_front();
                    bad  = "";
                    if (got.signal_bit !== want.signal_bit)
                        bad = {bad, " signal_bit"};
                    if (got.shared_bit !== want.shared_bit)
                        bad = {bad, " shared_bit"};
                    if (got.key_value !== want.key_value)
                        bad = {bad, " key_value"};
                    if (bad != "")
                        report($sformatf("key %0d wrong:%s (got %0b %0b %0d, want %0b %0b %0d)",
                                         keys_seen, bad, got.signal_bit, got.shared_bit,
                                         got.key_value, want.signal_bit, want.shared_bit,
                                         want.key_value));
                end
            end

            if (item_in.valid && item_in.ready)
            begin
                dot_acc = mac_mod(dot_acc, item_in.pub_elem, item_in.secret_elem, p);
                if (item_in.last_elem)
                begin
                    keys_due.push_back(reconcile(dot_acc, item_in.noise_term,
                                                 item_in.rand_bit, p));
                    dot_acc = '0;
                end
            end
        end
        fail_count   <= errors;
        keys_waiting <= keys_due.size();
    end

endmodule

// ===== verif/tb_lwe_shared_key_reconcile.sv =====
// ----------------------------------------------------------------------------
// tb_lwe_shared_key_reconcile
// Drives element pairs and modulus settings into the key reconciliation block
// while a checker beside it predicts every key. Directed pairs cover operand
// extremes, unreduced operands and the signal region edges; random vectors of
// pairs follow under a run of moduli, tiny and even ones among them.
// ----------------------------------------------------------------------------
module tb_lwe_shared_key_reconcile;

    localparam int     CLK_PERIOD      = 12;
    localparam int     RESET_CYCLES    = 4;
    // Let a last pair finish with margin before touching config
    localparam int     SETTLE_CYCLES   = 250;
    localparam int     PHASES          = 12;
    localparam int     PAIRS_PER_PHASE = 115;
    localparam longint LIMIT_CYCLES    = 1_200_000;

    logic                         clk;
    logic                         rst_n;
    logic                         psel;
    logic                         penable;
    logic                         pwrite;
    logic [lskr_pkg::PADDR_W-1:0] paddr;
    logic [lskr_pkg::PDATA_W-1:0] pwdata;
    logic [lskr_pkg::PDATA_W-1:0] prdata;
    logic                         pready;

    int                         tx_idle;
    int                         rx_idle;
    int                         pairs_sent;
    int                         fail_count;
    int                         keys_waiting;
    logic [lskr_pkg::MOD_W-1:0] moduli [PHASES];

    lskr_in_if  pair_ch ();
    lskr_out_if key_ch ();

    lwe_shared_key_reconcile dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .item_in (pair_ch),
        .result  (key_ch)
    );

    lskr_checker recon_watch (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .pready       (pready),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .item_in      (pair_ch),
        .result       (key_ch),
        .fail_count   (fail_count),
        .keys_waiting (keys_waiting)
    );

    initial
    begin
        clk = 1'b0;
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    // Hard stop in case the block hangs
    initial
    begin
        #(LIMIT_CYCLES * CLK_PERIOD);
        $display("lwe_shared_key_reconcile: mismatch");
        $finish;
    end

    // Result side: drop ready at random, at the rate the current phase asks
    initial
    begin
        key_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            key_ch.ready <= ($urandom_range(0, 99) >= rx_idle);
        end
    end

    // One APB transfer to the modulus register: setup, access, then an idle step
    // with psel low so that psel never drops and rises within one step.
    task automatic apb_xfer(input logic wr, input logic [lskr_pkg::PDATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= lskr_pkg::PADDR_W'({lskr_pkg::REG_MODULUS, 2'b00});
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    // Present one pair and hold it until the block takes the transaction.
    // Valid only drops when the sender decides to idle before this pair.
    task automatic send_pair(input logic [lskr_pkg::MOD_W-1:0] pub,
                             input logic [lskr_pkg::MOD_W-1:0] sec,
                             input logic [lskr_pkg::MOD_W-1:0] noise,
                             input logic                       rb,
                             input logic                       last);
        if ($urandom_range(0, 99) < tx_idle)
        begin
            pair_ch.valid <= 1'b0;
            do @(posedge clk); while ($urandom_range(0, 99) < tx_idle);
        end
        pair_ch.valid       <= 1'b1;
        pair_ch.pub_elem    <= pub;
        pair_ch.secret_elem <= sec;
        pair_ch.noise_term  <= noise;
        pair_ch.rand_bit    <= rb;
        pair_ch.last_elem   <= last;
        do @(posedge clk); while (!pair_ch.ready);
        pairs_sent++;
    endtask

    // Mostly reduced residues, with zero, p-1 and unreduced words mixed in
    function automatic logic [lskr_pkg::MOD_W-1:0] draw_elem(
        input logic [lskr_pkg::MOD_W-1:0] p);
        case ($urandom_range(0, 15))
            0:       return '0;
            1:       return (p < 2) ? '1 : p - 1;
            2, 3:    return $urandom();
            default: return (p < 2) ? $urandom() : $urandom() % p;
        endcase
    endfunction

    // Place k on and beside each edge of both signal regions with single-pair
    // vectors, secret 1, no noise: k is pub plus any partial sum left before.
    task automatic probe_regions(input logic [lskr_pkg::MOD_W-1:0] p);
        logic [lskr_pkg::MOD_W-1:0] q;
        logic [lskr_pkg::MOD_W-1:0] marks [6];
        q     = p / 4;
        marks = '{q, q + 1, q + 2, p - q - 1, p - q, p - q + 1};
        for (int rb = 0; rb < 2; rb++)
            foreach (marks[i])
                send_pair(marks[i], 1, '0, rb[0], 1'b1);
    endtask

    // One well-formed vector: a run of pairs closed by a last pair
    task automatic send_vector(input logic [lskr_pkg::MOD_W-1:0] p);
        int len;
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 24) : $urandom_range(1, 6);
        for (int i = 0; i < len; i++)
            send_pair(draw_elem(p), draw_elem(p), draw_elem(p), 1'($urandom_range(0, 1)),
                      i == len - 1);
    endtask

    // Drop valid, wait until no key is due, then let any trailing pair finish
    task automatic settle();
        pair_ch.valid <= 1'b0;
        do @(posedge clk); while (keys_waiting != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    initial
    begin
        int target;

        // Known values on every input from time zero
        rst_n               <= 1'b0;
        psel                <= 1'b0;
        penable             <= 1'b0;
        pwrite              <= 1'b0;
        paddr               <= '0;
        pwdata              <= '0;
        pair_ch.valid       <= 1'b0;
        pair_ch.pub_elem    <= '0;
        pair_ch.secret_elem <= '0;
        pair_ch.noise_term  <= '0;
        pair_ch.rand_bit    <= 1'b0;
        pair_ch.last_elem   <= 1'b0;
        pairs_sent = 0;
        tx_idle    = 21;
        rx_idle    = 66;

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part under the reset modulus: check it reads back first
        apb_xfer(1'b0, '0);
        send_pair('0, '0, '0, 1'b0, 1'b1);
        send_pair('1, '1, '1, 1'b0, 1'b0);
        send_pair(lskr_pkg::MODULUS_RESET - 1, lskr_pkg::MODULUS_RESET - 1,
                  lskr_pkg::MODULUS_RESET - 1, 1'b1, 1'b0);
        send_pair('1, '0, '1, 1'b1, 1'b1);
        // operands equal to p reduce to zero
        send_pair(lskr_pkg::MODULUS_RESET, lskr_pkg::MODULUS_RESET,
                  lskr_pkg::MODULUS_RESET, 1'b0, 1'b1);
        probe_regions(lskr_pkg::MODULUS_RESET);

        // Modulus run: extremes, tiny, even and a few drawn at random
        moduli = '{32'd3, '1, 32'hFFFF_FFFB, 32'd1, 32'd0, 32'd2, 32'h8000_0000,
                   32'd0, lskr_pkg::MODULUS_RESET, 32'd0, 32'd0, 32'd5};
        moduli[7]  = $urandom_range(3, 32'hFFFF_FFFF) | 32'd1;
        moduli[9]  = $urandom_range(4, 65535) & 32'hFFFF_FFFE;
        moduli[10] = $urandom_range(3, 255);

        for (int ph = 0; ph < PHASES; ph++)
        begin
            // Swap the idling sides after a third, stop idling after two thirds
            if (ph == PHASES / 3)
            begin
                tx_idle = 66;
                rx_idle = 21;
            end
            if (ph == 2 * PHASES / 3)
            begin
                tx_idle = 0;
                rx_idle = 0;
            end

            settle();
            apb_xfer(1'b1, moduli[ph]);
            apb_xfer(1'b0, '0);

            target = pairs_sent + PAIRS_PER_PHASE;
            probe_regions(moduli[ph]);
            while (pairs_sent < target)
                send_vector(moduli[ph]);

            // Leave a partial sum behind so the next modulus has to reduce it
            if (ph % 2 == 1)
                send_pair(draw_elem(moduli[ph]), draw_elem(moduli[ph]), '0, 1'b0, 1'b0);
        end

        settle();

        if (fail_count == 0)
            $display("lwe_shared_key_reconcile: match");
        else
            $display("lwe_shared_key_reconcile: mismatch");
        $finish;
    end

endmodule

// ===== lwe_shared_key_reconcile.f =====
hdl/lskr_pkg.sv
hdl/lskr_if.sv
hdl/lskr_modadd.sv
hdl/lskr_cfg.sv
hdl/lskr_ctrl.sv
hdl/lskr_dp.sv
hdl/lwe_shared_key_reconcile.sv
verif/lskr_checker.sv
verif/tb_lwe_shared_key_reconcile.sv
